// ----- hdl/bitplane_to_color_index_converter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the planar to chunky converter
// Short forms for the concurrent checks used by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TO_COLOR_INDEX_CONVERTER_CORE_ASSERT_SVH
`define BITPLANE_TO_COLOR_INDEX_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BCIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter check failed");

// Next-cycle implication, switched off while reset is held.
`define BCIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter check failed");

// Next-cycle implication that also watches the reset cycles themselves.
`define BCIC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("converter check failed");

`endif

// ----- hdl/bcic_pkg.sv -----
// ----------------------------------------------------------------------------
// bcic_pkg
// Shared types and constants of the planar to chunky converter.
// ----------------------------------------------------------------------------
package bcic_pkg;

    localparam int PIXELS      = 8;
    localparam int PLANE_BYTES = 8;
    localparam int IDX_W       = 8;
    localparam int SEL_W       = 3;
    localparam int COLOR_W     = 32;
    localparam int CNT_W       = 4;
    localparam int CFG_DATA_W  = 8;

    localparam int DEF_COLOR_ENTRIES = 256;
    localparam int DEF_MAX_PLANES    = 8;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef enum logic [1:0] {
        CFG_PLANE_COUNT  = 2'd0,
        CFG_PLANE_PICK   = 2'd1,
        CFG_PLANE_ON_OFF = 2'd2,
        CFG_COLOR_MASK   = 2'd3
    } t_cfg_index;

    localparam logic [CNT_W-1:0] RST_PLANE_COUNT  = 4'd2;
    localparam logic [IDX_W-1:0] RST_PLANE_PICK   = 8'd3;
    localparam logic [IDX_W-1:0] RST_PLANE_ON_OFF = 8'd0;
    localparam logic [IDX_W-1:0] RST_COLOR_MASK   = 8'hFF;

    typedef struct packed {
        logic [CNT_W-1:0] plane_count;
        logic [IDX_W-1:0] plane_pick;
        logic [IDX_W-1:0] plane_on_off;
        logic [IDX_W-1:0] color_mask;
    } t_cfg;

    // One classified request. For a table write, idx[0] holds the entry.
    typedef struct packed {
        logic                         op;
        logic [PIXELS-1:0][IDX_W-1:0] idx;
        logic [COLOR_W-1:0]           value;
    } t_item;

endpackage

// ----- hdl/bitplane_to_color_index_converter_core.sv -----
// ----------------------------------------------------------------------------
// bitplane_to_color_index_converter_core
// Planar to chunky converter: eight planar pixels in, eight colour words out.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Carries
//  input     push / full            i_op, i_entry_index, i_entry_value,
//                                   i_plane_byte_0 .. i_plane_byte_7
//  result    empty / pop            o_color_0 .. o_color_7
//  config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request is taken every cycle while full is low, and one result leaves
// every cycle while pop is held and a result is waiting. A convert request
// is first stored in the front queue and then looked up into the registered
// table copies, which form the result register; it can be taken from there
// when nothing waits ahead of it.
// Reset is synchronous; it empties the queue and the result register, loads
// the register reset values and leaves the colour table contents as they are.
// A stalled result holds its value, and the front queue keeps taking
// requests until it is full.
// ----------------------------------------------------------------------------
module bitplane_to_color_index_converter_core import bcic_pkg::*; #(
    parameter int COLOR_ENTRIES = DEF_COLOR_ENTRIES,
    parameter int MAX_PLANES    = DEF_MAX_PLANES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_op,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [COLOR_W-1:0]    i_entry_value,
    input  logic [IDX_W-1:0]      i_plane_byte_0,
    input  logic [IDX_W-1:0]      i_plane_byte_1,
    input  logic [IDX_W-1:0]      i_plane_byte_2,
    input  logic [IDX_W-1:0]      i_plane_byte_3,
    input  logic [IDX_W-1:0]      i_plane_byte_4,
    input  logic [IDX_W-1:0]      i_plane_byte_5,
    input  logic [IDX_W-1:0]      i_plane_byte_6,
    input  logic [IDX_W-1:0]      i_plane_byte_7,
    // Result side
    output logic                  empty,
    input  logic                  pop,
    output logic [COLOR_W-1:0]    o_color_0,
    output logic [COLOR_W-1:0]    o_color_1,
    output logic [COLOR_W-1:0]    o_color_2,
    output logic [COLOR_W-1:0]    o_color_3,
    output logic [COLOR_W-1:0]    o_color_4,
    output logic [COLOR_W-1:0]    o_color_5,
    output logic [COLOR_W-1:0]    o_color_6,
    output logic [COLOR_W-1:0]    o_color_7,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers. Software must write them only while the block is
    // idle; the block itself does not enforce this, and the front part uses them directly.
    logic [CNT_W-1:0] r_plane_count;
    logic [IDX_W-1:0] r_plane_pick;
    logic [IDX_W-1:0] r_plane_on_off;
    logic [IDX_W-1:0] r_color_mask;
    t_cfg             cfg;

    logic                             q_push;
    logic                             q_pop;
    logic                             q_valid;
    t_item                            front_item;
    t_item                            q_item;
    logic [PLANE_BYTES-1:0][IDX_W-1:0] plane_bytes;
    logic [PIXELS-1:0][COLOR_W-1:0]    color;

    // The register file takes a write request in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count  <= RST_PLANE_COUNT;
            r_plane_pick   <= RST_PLANE_PICK;
            r_plane_on_off <= RST_PLANE_ON_OFF;
            r_color_mask   <= RST_COLOR_MASK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[CNT_W-1:0];
                CFG_PLANE_PICK:   r_plane_pick   <= i_cfg_data;
                CFG_PLANE_ON_OFF: r_plane_on_off <= i_cfg_data;
                CFG_COLOR_MASK:   r_color_mask   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.plane_count  = r_plane_count;
    assign cfg.plane_pick   = r_plane_pick;
    assign cfg.plane_on_off = r_plane_on_off;
    assign cfg.color_mask   = r_color_mask;

    // Plane byte k belongs to the k-th picked index bit.
    assign plane_bytes[0] = i_plane_byte_0;
    assign plane_bytes[1] = i_plane_byte_1;
    assign plane_bytes[2] = i_plane_byte_2;
    assign plane_bytes[3] = i_plane_byte_3;
    assign plane_bytes[4] = i_plane_byte_4;
    assign plane_bytes[5] = i_plane_byte_5;
    assign plane_bytes[6] = i_plane_byte_6;
    assign plane_bytes[7] = i_plane_byte_7;

    // Front part: accepts the request and works out the pixel indices.
    bcic_front #(
        .MAX_PLANES (MAX_PLANES)
    ) u_front (
        .i_cfg         (cfg),
        .i_push        (push),
        .i_full        (full),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_plane_bytes (plane_bytes),
        .o_q_push      (q_push),
        .o_item        (front_item)
    );

    // The queue lets the front keep accepting while a result is stalled.
    bcic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back part: table writes, and lookups into the result register.
    bcic_back #(
        .COLOR_ENTRIES (COLOR_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .i_pop     (pop && !empty),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_color   (color)
    );

    assign o_color_0 = color[0];
    assign o_color_1 = color[1];
    assign o_color_2 = color[2];
    assign o_color_3 = color[3];
    assign o_color_4 = color[4];
    assign o_color_5 = color[5];
    assign o_color_6 = color[6];
    assign o_color_7 = color[7];

endmodule

// ----- hdl/bcic_front.sv -----
// ----------------------------------------------------------------------------
// bcic_front
// Accepts requests and turns a convert request into eight masked indices.
// ----------------------------------------------------------------------------
module bcic_front import bcic_pkg::*; #(
    parameter int MAX_PLANES = DEF_MAX_PLANES
) (
    input  t_cfg                               i_cfg,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic                               i_op,
    input  logic [IDX_W-1:0]                   i_entry_index,
    input  logic [COLOR_W-1:0]                 i_entry_value,
    input  logic [PLANE_BYTES-1:0][IDX_W-1:0]  i_plane_bytes,
    output logic                               o_q_push,
    output t_item                              o_item
);

    logic [CNT_W-1:0]                 planes;
    logic [CNT_W-1:0]                 rank;
    logic [IDX_W-1:0]                 take;
    logic [IDX_W-1:0][SEL_W-1:0]      sel;
    logic [IDX_W-1:0]                 base;
    logic [PIXELS-1:0][IDX_W-1:0]     pix_idx;

    assign o_q_push = i_push && !i_full;

    // Stored planes are handed out in order to the picked bits, lowest first,
    // until the plane count is used up.
    always_comb begin
        planes = (i_cfg.plane_count > CNT_W'(MAX_PLANES)) ? CNT_W'(MAX_PLANES)
                                                          : i_cfg.plane_count;
        rank = '0;
        for (int b = 0; b < IDX_W; b++) begin
            sel[b]  = rank[SEL_W-1:0];
            take[b] = i_cfg.plane_pick[b] && (rank < planes);
            if (i_cfg.plane_pick[b]) begin
                rank = rank + CNT_W'(1);
            end
        end
    end

    assign base = i_cfg.plane_on_off & ~i_cfg.plane_pick;

    always_comb begin
        for (int p = 0; p < PIXELS; p++) begin
            for (int b = 0; b < IDX_W; b++) begin
                pix_idx[p][b] = take[b] ? i_plane_bytes[sel[b]][PIXELS-1-p] : base[b];
            end
            pix_idx[p] = pix_idx[p] & i_cfg.color_mask;
        end
    end

    always_comb begin
        o_item.op    = i_op;
        o_item.value = i_entry_value;
        o_item.idx   = pix_idx;
        if (i_op == OP_WRITE) begin
            o_item.idx[0] = i_entry_index;
        end
    end

endmodule

// ----- hdl/bcic_queue.sv -----
// ----------------------------------------------------------------------------
// bcic_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module bcic_queue import bcic_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_Q-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_Q'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_Q'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/bcic_back.sv -----
// ----------------------------------------------------------------------------
// bcic_back
// Carries out table writes and the eight colour lookups of a convert.
// ----------------------------------------------------------------------------
module bcic_back import bcic_pkg::*; #(
    parameter int COLOR_ENTRIES = DEF_COLOR_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  t_item                             i_q_item,
    input  logic                              i_pop,
    output logic                              o_q_pop,
    output logic                              o_empty,
    output logic [PIXELS-1:0][COLOR_W-1:0]    o_color
);

    localparam int ADDR_W = $clog2(COLOR_ENTRIES);

    logic              r_out_valid, n_out_valid;
    logic              issue_ok;
    logic              wr_en;
    logic              rd_en;
    logic [PIXELS-1:0] in_range;

    // The read registers of the table copies are the result register itself:
    // a new lookup may start when it is empty or being emptied.
    assign issue_ok = !r_out_valid || i_pop;
    assign o_q_pop  = i_q_valid && ((i_q_item.op == OP_WRITE) || issue_ok);
    assign rd_en    = o_q_pop && (i_q_item.op == OP_CONVERT);
    assign wr_en    = o_q_pop && (i_q_item.op == OP_WRITE) && in_range[0];
    assign o_empty  = !r_out_valid;

    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            in_range[k] = ({1'b0, i_q_item.idx[k]} < (IDX_W + 1)'(COLOR_ENTRIES));
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (rd_en) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // One copy of the table per pixel lane; every copy takes every write.
    for (genvar k = 0; k < PIXELS; k++) begin : g_lane
        logic [COLOR_W-1:0] r_mem [COLOR_ENTRIES];
        logic [COLOR_W-1:0] r_rd;
        logic               r_zero;

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[i_q_item.idx[0][ADDR_W-1:0]] <= i_q_item.value;
            end
            if (rd_en) begin
                r_rd   <= r_mem[i_q_item.idx[k][ADDR_W-1:0]];
                r_zero <= !in_range[k];
            end
        end

        assign o_color[k] = r_zero ? '0 : r_rd;
    end

endmodule

// ----- hdl/bcic_checker.sv -----
// ----------------------------------------------------------------------------
// bcic_port_checks
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "bitplane_to_color_index_converter_core_assert.svh"

module bcic_port_checks import bcic_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [COLOR_W-1:0] i_color_0
);

    // Reset empties both the request queue and the result register.
    `BCIC_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, empty && !full)

    // No result appears after reset while no request has been pushed.
    `BCIC_ASSERT_NEXT_ALWAYS(a_no_early_result, i_clk, !i_rst_n ##1 (i_rst_n && !push), empty)

    // The request queue only fills up behind a waiting result.
    `BCIC_ASSERT_IMPLY(a_full_needs_result, i_clk, i_rst_n, full, !empty)

    // A result that is not taken stays on the ports unchanged.
    `BCIC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(i_color_0))

endmodule

bind bitplane_to_color_index_converter_core bcic_port_checks u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .i_color_0 (o_color_0)
);
